// ===== rtl/can_transceiver_mode_and_rxd_macros.svh =====
// Assertion macros for the CAN transceiver mode and RXD block.
// Included by the top level; depends on nothing else.
`ifndef CAN_TRANSCEIVER_MODE_AND_RXD_MACROS_SVH
`define CAN_TRANSCEIVER_MODE_AND_RXD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CTMR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CTMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ctmr_pkg.sv =====
// Shared types, codes and constants of the CAN transceiver mode and RXD block.
// No dependencies; used by every module of the block.
package ctmr_pkg;

	localparam int unsigned MV_W      = 13;
	localparam int unsigned TIME_W    = 64;
	localparam int unsigned TMO_W     = 32;
	localparam int unsigned DLY_W     = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DOM_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REC_THR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIL_TMO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_DLY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_DLY = 3'd4;

	localparam logic [MV_W-1:0]  RST_DOM_THR  = 13'd900;
	localparam logic [MV_W-1:0]  RST_REC_THR  = 13'd500;
	localparam logic [TMO_W-1:0] RST_SIL_TMO  = 32'd1000000000;
	localparam logic [DLY_W-1:0] RST_FALL_DLY = 16'd145;
	localparam logic [DLY_W-1:0] RST_RISE_DLY = 16'd150;

	// Operating mode codes
	localparam logic [1:0] OPM_OFF    = 2'd0;
	localparam logic [1:0] OPM_NORMAL = 2'd1;
	localparam logic [1:0] OPM_SILENT = 2'd2;

	// Bus classification codes
	localparam logic [1:0] BUS_DOM = 2'd0;
	localparam logic [1:0] BUS_REC = 2'd1;
	localparam logic [1:0] BUS_IND = 2'd2;

	// Reported state codes
	localparam logic [1:0] CODE_OFF           = 2'd0;
	localparam logic [1:0] CODE_AUTO_INACTIVE = 2'd1;
	localparam logic [1:0] CODE_AUTO_ACTIVE   = 2'd2;
	localparam logic [1:0] CODE_ACTIVE        = 2'd3;

	localparam logic [MV_W-1:0] CANH_DOM_MV = 13'd3500;
	localparam logic [MV_W-1:0] CANL_DOM_MV = 13'd1500;
	localparam logic [MV_W-1:0] CAN_REC_MV  = 13'd2500;

	typedef enum logic [3:0] {
		ST_OFF           = 4'b0001,
		ST_AUTO_INACTIVE = 4'b0010,
		ST_AUTO_ACTIVE   = 4'b0100,
		ST_ACTIVE        = 4'b1000
	} ctmr_state_t;

	typedef struct packed {
		logic [MV_W-1:0]  dom_thr;
		logic [MV_W-1:0]  rec_thr;
		logic [TMO_W-1:0] sil_tmo;
		logic [DLY_W-1:0] fall_dly;
		logic [DLY_W-1:0] rise_dly;
	} ctmr_cfg_t;

	// One classified sample, as queued between front and back
	typedef struct packed {
		logic [1:0]        op_mode;
		logic              txd_low;
		logic [1:0]        bus_class;
		logic [TIME_W-1:0] now_ns;
		logic [TIME_W-1:0] due_ns;
		logic              due_passed;
	} ctmr_item_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [Q_CNT_W-1:0] count;
	} ctmr_q_status_t;

	function automatic logic [1:0] state_code(input ctmr_state_t st);
		logic [1:0] code;
		case (st)
			ST_OFF:           code = CODE_OFF;
			ST_AUTO_INACTIVE: code = CODE_AUTO_INACTIVE;
			ST_AUTO_ACTIVE:   code = CODE_AUTO_ACTIVE;
			ST_ACTIVE:        code = CODE_ACTIVE;
			default:          code = CODE_OFF;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/ctmr_front.sv =====
// Front end: classifies the differential bus voltage and works out the RXD due time.
// Depends on ctmr_pkg.
module ctmr_front (
	input  ctmr_pkg::ctmr_cfg_t              cfg,
	input  logic [1:0]                       op_mode,
	input  logic                             txd_low,
	input  logic [ctmr_pkg::MV_W-1:0]        canh_mv,
	input  logic [ctmr_pkg::MV_W-1:0]        canl_mv,
	input  logic [ctmr_pkg::TIME_W-1:0]      now_ns,
	input  logic [ctmr_pkg::TIME_W-1:0]      sched_ns,
	output ctmr_pkg::ctmr_item_t             item
);

	logic signed [ctmr_pkg::MV_W:0]     vdiff;
	logic [1:0]                         bus;
	logic [ctmr_pkg::DLY_W-1:0]         dly;
	logic [ctmr_pkg::TIME_W-1:0]        due;

	assign vdiff = $signed({1'b0, canh_mv}) - $signed({1'b0, canl_mv});

	// Dominant test first, so crossed thresholds resolve to dominant
	always_comb begin
		if (vdiff >= $signed({1'b0, cfg.dom_thr})) begin
			bus = ctmr_pkg::BUS_DOM;
		end else if (vdiff <= $signed({1'b0, cfg.rec_thr})) begin
			bus = ctmr_pkg::BUS_REC;
		end else begin
			bus = ctmr_pkg::BUS_IND;
		end
	end

	// Going recessive takes the rising delay, going dominant the falling one
	assign dly = (bus == ctmr_pkg::BUS_REC) ? cfg.rise_dly : cfg.fall_dly;
	assign due = sched_ns + {{(ctmr_pkg::TIME_W - ctmr_pkg::DLY_W){1'b0}}, dly};

	always_comb begin
		item.op_mode    = op_mode;
		item.txd_low    = txd_low;
		item.bus_class  = bus;
		item.now_ns     = now_ns;
		item.due_ns     = due;
		item.due_passed = (due <= now_ns);
	end

endmodule

// ===== rtl/ctmr_queue.sv =====
// Short register queue between the classifier and the state machine.
// Depends on ctmr_pkg.
module ctmr_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  ctmr_pkg::ctmr_item_t   wr_item,
	input  logic                   rd_en,
	output ctmr_pkg::ctmr_item_t   rd_item,
	output ctmr_pkg::ctmr_q_status_t status
);

	ctmr_pkg::ctmr_item_t              mem_q [ctmr_pkg::Q_DEPTH];
	logic [ctmr_pkg::Q_PTR_W-1:0]      wr_ptr_q;
	logic [ctmr_pkg::Q_PTR_W-1:0]      rd_ptr_q;
	logic [ctmr_pkg::Q_CNT_W-1:0]      count_q;
	logic                              do_wr;
	logic                              do_rd;

	assign status.full  = (count_q == ctmr_pkg::Q_CNT_W'(ctmr_pkg::Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;

	assign do_wr = wr_en && !status.full;
	assign do_rd = rd_en && !status.empty;

	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				if (wr_ptr_q == ctmr_pkg::Q_PTR_W'(ctmr_pkg::Q_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_rd) begin
				if (rd_ptr_q == ctmr_pkg::Q_PTR_W'(ctmr_pkg::Q_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ctmr_back.sv =====
// Back end: transceiver state machine, bus drive and delayed RXD, with output register.
// Depends on ctmr_pkg.
module ctmr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ctmr_pkg::TMO_W-1:0]      sil_tmo,
	input  logic                            item_valid,
	input  ctmr_pkg::ctmr_item_t            item,
	output logic                            item_take,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      fsm_state,
	output logic                            drv_en,
	output logic                            rcv_en,
	output logic [ctmr_pkg::MV_W-1:0]       canh_out_mv,
	output logic [ctmr_pkg::MV_W-1:0]       canl_out_mv,
	output logic                            rxd_level,
	output logic [1:0]                      bus_class
);

	ctmr_pkg::ctmr_state_t              state_q, state_n;
	logic                               rxd_now_q, rxd_now_n;
	logic                               rxd_wait_q, rxd_wait_n;
	logic                               rxd_next_q, rxd_next_n;
	logic [ctmr_pkg::TIME_W-1:0]        rxd_due_q, rxd_due_n;
	logic [ctmr_pkg::TIME_W-1:0]        last_act_q, last_act_n;
	logic [ctmr_pkg::TIME_W-1:0]        elapsed;
	logic                               out_valid_q;
	logic                               supply, wants_active, bus_dom, timed_out;
	logic                               drv_n, rcv_n, drive_dom;
	logic                               target, rxd_cur, wait_cur;

	assign item_take = item_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign supply       = (item.op_mode != ctmr_pkg::OPM_OFF);
	assign wants_active = (item.op_mode == ctmr_pkg::OPM_NORMAL) ||
	                      (item.op_mode == ctmr_pkg::OPM_SILENT);
	assign bus_dom      = (item.bus_class == ctmr_pkg::BUS_DOM);

	// A dominant bus refreshes activity; a zero time counts as unset
	assign last_act_n = (bus_dom || last_act_q == '0) ? item.now_ns : last_act_q;
	assign elapsed    = item.now_ns - last_act_n;
	assign timed_out  = (elapsed > {{(ctmr_pkg::TIME_W - ctmr_pkg::TMO_W){1'b0}}, sil_tmo});

	always_comb begin
		state_n = state_q;
		case (state_q)
			ctmr_pkg::ST_OFF: begin
				if (supply) state_n = ctmr_pkg::ST_AUTO_INACTIVE;
			end
			ctmr_pkg::ST_AUTO_INACTIVE: begin
				if (!supply) state_n = ctmr_pkg::ST_OFF;
				else if (wants_active) state_n = ctmr_pkg::ST_ACTIVE;
				else if (bus_dom) state_n = ctmr_pkg::ST_AUTO_ACTIVE;
			end
			ctmr_pkg::ST_AUTO_ACTIVE: begin
				if (!supply) state_n = ctmr_pkg::ST_OFF;
				else if (wants_active) state_n = ctmr_pkg::ST_ACTIVE;
				else if (timed_out) state_n = ctmr_pkg::ST_AUTO_INACTIVE;
			end
			ctmr_pkg::ST_ACTIVE: begin
				if (!supply) begin
					state_n = ctmr_pkg::ST_OFF;
				end else if (!wants_active) begin
					state_n = (bus_dom || !timed_out) ? ctmr_pkg::ST_AUTO_ACTIVE
					                                  : ctmr_pkg::ST_AUTO_INACTIVE;
				end
			end
			default: state_n = ctmr_pkg::ST_OFF;
		endcase
	end

	// Enables follow the state after this transfer's transition
	always_comb begin
		case (state_n)
			ctmr_pkg::ST_OFF: begin
				drv_n = 1'b0;
				rcv_n = 1'b0;
			end
			ctmr_pkg::ST_ACTIVE: begin
				drv_n = (item.op_mode == ctmr_pkg::OPM_NORMAL);
				rcv_n = wants_active;
			end
			default: begin
				drv_n = 1'b0;
				rcv_n = 1'b1;
			end
		endcase
	end

	assign drive_dom = item.txd_low && drv_n;

	always_comb begin
		rxd_now_n  = rxd_now_q;
		rxd_wait_n = rxd_wait_q;
		rxd_next_n = rxd_next_q;
		rxd_due_n  = rxd_due_q;
		rxd_cur    = rxd_now_q;
		wait_cur   = rxd_wait_q;
		target     = (item.bus_class == ctmr_pkg::BUS_REC);
		if (!rcv_n) begin
			// Receiver off: force recessive, drop any pending edge
			rxd_now_n  = 1'b1;
			rxd_wait_n = 1'b0;
		end else begin
			if (rxd_wait_q && item.now_ns >= rxd_due_q) begin
				rxd_cur  = rxd_next_q;
				wait_cur = 1'b0;
			end
			rxd_now_n  = rxd_cur;
			rxd_wait_n = wait_cur;
			if (item.bus_class != ctmr_pkg::BUS_IND && target != rxd_cur &&
			    !(wait_cur && rxd_next_q == target)) begin
				if (item.due_passed) begin
					rxd_now_n  = target;
					rxd_wait_n = 1'b0;
				end else begin
					rxd_wait_n = 1'b1;
					rxd_next_n = target;
					rxd_due_n  = item.due_ns;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctmr_pkg::ST_OFF;
			rxd_now_q   <= 1'b1;
			rxd_wait_q  <= 1'b0;
			last_act_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				state_q    <= state_n;
				rxd_now_q  <= rxd_now_n;
				rxd_wait_q <= rxd_wait_n;
				last_act_q <= last_act_n;
			end
			if (item_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pending edge and result payload hold without reset
	always_ff @(posedge clk) begin
		if (item_take) begin
			rxd_next_q  <= rxd_next_n;
			rxd_due_q   <= rxd_due_n;
			fsm_state   <= ctmr_pkg::state_code(state_n);
			drv_en      <= drv_n;
			rcv_en      <= rcv_n;
			canh_out_mv <= drive_dom ? ctmr_pkg::CANH_DOM_MV : ctmr_pkg::CAN_REC_MV;
			canl_out_mv <= drive_dom ? ctmr_pkg::CANL_DOM_MV : ctmr_pkg::CAN_REC_MV;
			rxd_level   <= rxd_now_n;
			bus_class   <= item.bus_class;
		end
	end

endmodule

// ===== rtl/can_transceiver_mode_and_rxd.sv =====
// CAN transceiver mode control and RXD path. An accepted transfer is registered in the
// queue, then in the back end's output register; throughput one sample per cycle while
// out_ready holds, set by the back end's state and RXD update on the queue head.
// Reset: arst_n clears the state machine, RXD, activity time, queue and output valid
// at once and loads the register defaults; no clearing pass.
`include "can_transceiver_mode_and_rxd_macros.svh"

module can_transceiver_mode_and_rxd (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ctmr_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ctmr_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        op_mode,
	input  logic                              txd_low,
	input  logic [ctmr_pkg::MV_W-1:0]         canh_mv,
	input  logic [ctmr_pkg::MV_W-1:0]         canl_mv,
	input  logic [ctmr_pkg::TIME_W-1:0]       now_ns,
	input  logic [ctmr_pkg::TIME_W-1:0]       sched_ns,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        fsm_state,
	output logic                              drv_en,
	output logic                              rcv_en,
	output logic [ctmr_pkg::MV_W-1:0]         canh_out_mv,
	output logic [ctmr_pkg::MV_W-1:0]         canl_out_mv,
	output logic                              rxd_level,
	output logic [1:0]                        bus_class
);

	ctmr_pkg::ctmr_cfg_t       cfg_q;
	ctmr_pkg::ctmr_item_t      front_item;
	ctmr_pkg::ctmr_item_t      head_item;
	ctmr_pkg::ctmr_q_status_t  q_status;
	logic                      head_take;

	// Register file; writes beyond the list fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dom_thr  <= ctmr_pkg::RST_DOM_THR;
			cfg_q.rec_thr  <= ctmr_pkg::RST_REC_THR;
			cfg_q.sil_tmo  <= ctmr_pkg::RST_SIL_TMO;
			cfg_q.fall_dly <= ctmr_pkg::RST_FALL_DLY;
			cfg_q.rise_dly <= ctmr_pkg::RST_RISE_DLY;
		end else if (cfg_we) begin
			case (cfg_idx)
				ctmr_pkg::REG_DOM_THR:  cfg_q.dom_thr  <= cfg_data[ctmr_pkg::MV_W-1:0];
				ctmr_pkg::REG_REC_THR:  cfg_q.rec_thr  <= cfg_data[ctmr_pkg::MV_W-1:0];
				ctmr_pkg::REG_SIL_TMO:  cfg_q.sil_tmo  <= cfg_data[ctmr_pkg::TMO_W-1:0];
				ctmr_pkg::REG_FALL_DLY: cfg_q.fall_dly <= cfg_data[ctmr_pkg::DLY_W-1:0];
				ctmr_pkg::REG_RISE_DLY: cfg_q.rise_dly <= cfg_data[ctmr_pkg::DLY_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !q_status.full;

	ctmr_front u_front (
		.cfg      (cfg_q),
		.op_mode  (op_mode),
		.txd_low  (txd_low),
		.canh_mv  (canh_mv),
		.canl_mv  (canl_mv),
		.now_ns   (now_ns),
		.sched_ns (sched_ns),
		.item     (front_item)
	);

	ctmr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_valid),
		.wr_item (front_item),
		.rd_en   (head_take),
		.rd_item (head_item),
		.status  (q_status)
	);

	ctmr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.sil_tmo     (cfg_q.sil_tmo),
		.item_valid  (!q_status.empty),
		.item        (head_item),
		.item_take   (head_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fsm_state   (fsm_state),
		.drv_en      (drv_en),
		.rcv_en      (rcv_en),
		.canh_out_mv (canh_out_mv),
		.canl_out_mv (canl_out_mv),
		.rxd_level   (rxd_level),
		.bus_class   (bus_class)
	);

	`CTMR_ASSERT_IMPL(a_drv_only_active, clk, arst_n, out_valid && drv_en, rcv_en && fsm_state == ctmr_pkg::CODE_ACTIVE, "driver enabled outside active state")
	`CTMR_ASSERT_IMPL(a_rxd_idle_when_off, clk, arst_n, out_valid && !rcv_en, rxd_level, "RXD not recessive with receiver off")
	`CTMR_ASSERT_IMPL(a_dom_needs_drv, clk, arst_n, out_valid && canh_out_mv == ctmr_pkg::CANH_DOM_MV, drv_en, "bus driven dominant with driver off")
	`CTMR_ASSERT_NEXT(a_accept_fills_queue, clk, arst_n, in_valid && in_ready, !q_status.empty, "accepted transfer missing from queue")

endmodule

// ===== verif/tb_can_transceiver_mode_and_rxd.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the CAN transceiver mode control and RXD path.
// Predicts every result from its own model of the state machine and RXD delay.
// Depends on ctmr_pkg and the can_transceiver_mode_and_rxd top level.
module tb_can_transceiver_mode_and_rxd;

	localparam logic [1:0]                     OPM_LOW_POWER = 2'd3;
	localparam logic [ctmr_pkg::CFG_IDX_W-1:0] REG_PAST_END  = 3'd5;
	localparam logic [ctmr_pkg::CFG_IDX_W-1:0] REG_IDX_MAX   = 3'd7;
	localparam logic [ctmr_pkg::TIME_W-1:0]    TIME_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [1:0]                  mode;
		logic                        txd;
		logic [ctmr_pkg::MV_W-1:0]   canh;
		logic [ctmr_pkg::MV_W-1:0]   canl;
		logic [ctmr_pkg::TIME_W-1:0] now;
		logic [ctmr_pkg::TIME_W-1:0] sched;
	} sample_t;

	typedef struct {
		logic [1:0]                st;
		logic                      drv;
		logic                      rcv;
		logic [ctmr_pkg::MV_W-1:0] canh;
		logic [ctmr_pkg::MV_W-1:0] canl;
		logic                      rxd;
		logic [1:0]                cls;
	} pins_t;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [ctmr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [ctmr_pkg::CFG_DAT_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [1:0]                     op_mode = '0;
	logic                           txd_low = 1'b0;
	logic [ctmr_pkg::MV_W-1:0]      canh_mv = '0;
	logic [ctmr_pkg::MV_W-1:0]      canl_mv = '0;
	logic [ctmr_pkg::TIME_W-1:0]    now_ns = '0;
	logic [ctmr_pkg::TIME_W-1:0]    sched_ns = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [1:0]                     fsm_state;
	logic                           drv_en;
	logic                           rcv_en;
	logic [ctmr_pkg::MV_W-1:0]      canh_out_mv;
	logic [ctmr_pkg::MV_W-1:0]      canl_out_mv;
	logic                           rxd_level;
	logic [1:0]                     bus_class;

	can_transceiver_mode_and_rxd u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op_mode     (op_mode),
		.txd_low     (txd_low),
		.canh_mv     (canh_mv),
		.canl_mv     (canl_mv),
		.now_ns      (now_ns),
		.sched_ns    (sched_ns),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fsm_state   (fsm_state),
		.drv_en      (drv_en),
		.rcv_en      (rcv_en),
		.canh_out_mv (canh_out_mv),
		.canl_out_mv (canl_out_mv),
		.rxd_level   (rxd_level),
		.bus_class   (bus_class)
	);

	// Register shadow
	logic [ctmr_pkg::MV_W-1:0]  dom_thr_mv;
	logic [ctmr_pkg::MV_W-1:0]  rec_thr_mv;
	logic [ctmr_pkg::TMO_W-1:0] quiet_limit_ns;
	logic [ctmr_pkg::DLY_W-1:0] fall_ns;
	logic [ctmr_pkg::DLY_W-1:0] rise_ns;

	// Predicted transceiver state
	logic [1:0]                  mode_code;
	logic                        drv_on;
	logic                        rcv_on;
	logic                        rxd_pin;
	logic                        rxd_queued;
	logic                        rxd_queued_val;
	logic [ctmr_pkg::TIME_W-1:0] rxd_due;
	logic [ctmr_pkg::TIME_W-1:0] last_dom_ns;

	sample_t                     samples_to_send[$];
	pins_t                       bus_results_due[$];
	sample_t                     next_sample;
	sample_t                     taken;
	pins_t                       want;
	int                          samples_loaded = 0;
	int                          results_matched = 0;
	int                          mismatch_count = 0;
	int                          send_gap = 0;
	int                          hold_off = 0;
	logic                        steady = 1'b0;
	logic [ctmr_pkg::TIME_W-1:0] clock_ns;
	logic [1:0]                  cur_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic reset_model();
		dom_thr_mv     = ctmr_pkg::RST_DOM_THR;
		rec_thr_mv     = ctmr_pkg::RST_REC_THR;
		quiet_limit_ns = ctmr_pkg::RST_SIL_TMO;
		fall_ns        = ctmr_pkg::RST_FALL_DLY;
		rise_ns        = ctmr_pkg::RST_RISE_DLY;
		mode_code      = ctmr_pkg::CODE_OFF;
		drv_on         = 1'b0;
		rcv_on         = 1'b0;
		rxd_pin        = 1'b1;
		rxd_queued     = 1'b0;
		rxd_queued_val = 1'b1;
		rxd_due        = '0;
		last_dom_ns    = '0;
	endtask

	function automatic pins_t predict_transceiver_step(input sample_t s);
		pins_t                       p;
		int                          vdiff;
		logic [1:0]                  cls;
		logic                        powered;
		logic                        wants_on;
		logic                        target;
		logic [ctmr_pkg::TIME_W-1:0] quiet;
		logic [ctmr_pkg::TIME_W-1:0] due;
		vdiff = int'(s.canh) - int'(s.canl);
		// dominant test first, so crossed thresholds resolve to dominant
		if (vdiff >= int'(dom_thr_mv))
			cls = ctmr_pkg::BUS_DOM;
		else if (vdiff <= int'(rec_thr_mv))
			cls = ctmr_pkg::BUS_REC;
		else
			cls = ctmr_pkg::BUS_IND;

		powered  = (s.mode != ctmr_pkg::OPM_OFF);
		wants_on = (s.mode == ctmr_pkg::OPM_NORMAL) || (s.mode == ctmr_pkg::OPM_SILENT);
		if (cls == ctmr_pkg::BUS_DOM)
			last_dom_ns = s.now;
		// zero activity time counts as never set
		if (last_dom_ns == '0)
			last_dom_ns = s.now;
		quiet = s.now - last_dom_ns;

		case (mode_code)
			ctmr_pkg::CODE_OFF: begin
				if (powered)
					mode_code = ctmr_pkg::CODE_AUTO_INACTIVE;
			end
			ctmr_pkg::CODE_AUTO_INACTIVE: begin
				if (!powered) begin
					mode_code = ctmr_pkg::CODE_OFF;
				end else if (wants_on) begin
					mode_code = ctmr_pkg::CODE_ACTIVE;
				end else if (cls == ctmr_pkg::BUS_DOM) begin
					mode_code   = ctmr_pkg::CODE_AUTO_ACTIVE;
					last_dom_ns = s.now;
				end
			end
			ctmr_pkg::CODE_AUTO_ACTIVE: begin
				if (!powered)
					mode_code = ctmr_pkg::CODE_OFF;
				else if (wants_on)
					mode_code = ctmr_pkg::CODE_ACTIVE;
				else if (quiet > {32'd0, quiet_limit_ns})
					mode_code = ctmr_pkg::CODE_AUTO_INACTIVE;
			end
			default: begin
				if (!powered) begin
					mode_code = ctmr_pkg::CODE_OFF;
				end else if (!wants_on) begin
					if (cls == ctmr_pkg::BUS_DOM || quiet <= {32'd0, quiet_limit_ns})
						mode_code = ctmr_pkg::CODE_AUTO_ACTIVE;
					else
						mode_code = ctmr_pkg::CODE_AUTO_INACTIVE;
				end
			end
		endcase

		if (mode_code == ctmr_pkg::CODE_OFF) begin
			drv_on = 1'b0;
			rcv_on = 1'b0;
		end else if (mode_code == ctmr_pkg::CODE_ACTIVE) begin
			drv_on = (s.mode == ctmr_pkg::OPM_NORMAL);
			rcv_on = wants_on;
		end else begin
			drv_on = 1'b0;
			rcv_on = 1'b1;
		end

		if (!rcv_on) begin
			rxd_pin    = 1'b1;
			rxd_queued = 1'b0;
		end else begin
			if (rxd_queued && s.now >= rxd_due) begin
				rxd_pin    = rxd_queued_val;
				rxd_queued = 1'b0;
			end
			// an indeterminate bus schedules nothing new
			if (cls != ctmr_pkg::BUS_IND) begin
				target = (cls == ctmr_pkg::BUS_REC);
				if (target != rxd_pin && !(rxd_queued && rxd_queued_val == target)) begin
					due = s.sched + {48'd0, (target ? rise_ns : fall_ns)};
					if (due <= s.now) begin
						rxd_pin    = target;
						rxd_queued = 1'b0;
					end else begin
						rxd_queued     = 1'b1;
						rxd_queued_val = target;
						rxd_due        = due;
					end
				end
			end
		end

		p.st   = mode_code;
		p.drv  = drv_on;
		p.rcv  = rcv_on;
		p.canh = (s.txd && drv_on) ? ctmr_pkg::CANH_DOM_MV : ctmr_pkg::CAN_REC_MV;
		p.canl = (s.txd && drv_on) ? ctmr_pkg::CANL_DOM_MV : ctmr_pkg::CAN_REC_MV;
		p.rxd  = rxd_pin;
		p.cls  = cls;
		return p;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	task automatic queue_sample(input logic [1:0] mode, input logic txd,
			input logic [ctmr_pkg::MV_W-1:0] h, input logic [ctmr_pkg::MV_W-1:0] l,
			input logic [ctmr_pkg::TIME_W-1:0] now,
			input logic [ctmr_pkg::TIME_W-1:0] sched);
		sample_t s;
		s.mode  = mode;
		s.txd   = txd;
		s.canh  = h;
		s.canl  = l;
		s.now   = now;
		s.sched = sched;
		samples_to_send.push_back(s);
		samples_loaded++;
	endtask

	task automatic write_reg(input logic [ctmr_pkg::CFG_IDX_W-1:0] idx,
			input logic [ctmr_pkg::CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ctmr_pkg::REG_DOM_THR:  dom_thr_mv     = val[ctmr_pkg::MV_W-1:0];
			ctmr_pkg::REG_REC_THR:  rec_thr_mv     = val[ctmr_pkg::MV_W-1:0];
			ctmr_pkg::REG_SIL_TMO:  quiet_limit_ns = val[ctmr_pkg::TMO_W-1:0];
			ctmr_pkg::REG_FALL_DLY: fall_ns        = val[ctmr_pkg::DLY_W-1:0];
			ctmr_pkg::REG_RISE_DLY: rise_ns        = val[ctmr_pkg::DLY_W-1:0];
			default: ;
		endcase
	endtask

	// Hold until every queued sample has come back, then let the pipe settle
	task automatic wait_bus_quiet();
		while (results_matched != samples_loaded)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input int phase);
		logic [ctmr_pkg::MV_W-1:0]  d;
		logic [ctmr_pkg::MV_W-1:0]  r;
		logic [ctmr_pkg::TMO_W-1:0] t;
		logic [ctmr_pkg::DLY_W-1:0] f;
		logic [ctmr_pkg::DLY_W-1:0] g;
		case (phase)
			0: begin
				d = ctmr_pkg::RST_DOM_THR;
				r = ctmr_pkg::RST_REC_THR;
				t = ctmr_pkg::RST_SIL_TMO;
				f = ctmr_pkg::RST_FALL_DLY;
				g = ctmr_pkg::RST_RISE_DLY;
			end
			1: begin
				d = '0;
				r = '0;
				t = '0;
				f = '0;
				g = '0;
			end
			2: begin
				d = 13'd5000;
				r = 13'd5000;
				t = 32'hFFFF_FFFF;
				f = 16'hFFFF;
				g = 16'hFFFF;
			end
			default: begin
				d = ctmr_pkg::MV_W'($urandom_range(200, 1500));
				r = ctmr_pkg::MV_W'($urandom_range(0, 1200));
				t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
				f = ctmr_pkg::DLY_W'($urandom_range(0, 500));
				g = ctmr_pkg::DLY_W'($urandom_range(0, 500));
			end
		endcase
		write_reg(ctmr_pkg::REG_DOM_THR, {19'd0, d});
		write_reg(ctmr_pkg::REG_REC_THR, {19'd0, r});
		write_reg(ctmr_pkg::REG_SIL_TMO, t);
		write_reg(ctmr_pkg::REG_FALL_DLY, {16'd0, f});
		write_reg(ctmr_pkg::REG_RISE_DLY, {16'd0, g});
	endtask

	// Mostly a steadily advancing clock with a persistent mode; now and then
	// a jump, a wrap near the top of the time range or a random timestamp.
	task automatic queue_random_sample();
		int                          pick;
		int                          diff;
		int                          lo;
		logic [ctmr_pkg::TIME_W-1:0] sched;
		logic [ctmr_pkg::MV_W-1:0]   h;
		logic [ctmr_pkg::MV_W-1:0]   l;
		if ($urandom_range(0, 11) == 0) begin
			pick = $urandom_range(0, 9);
			cur_mode = (pick == 0) ? ctmr_pkg::OPM_OFF : (pick <= 3) ? ctmr_pkg::OPM_NORMAL :
				(pick <= 5) ? ctmr_pkg::OPM_SILENT : OPM_LOW_POWER;
		end

		pick = $urandom_range(0, 99);
		if (pick < 2)
			clock_ns = {$urandom, $urandom};
		else if (pick < 3)
			clock_ns = TIME_MAX - 64'($urandom_range(0, 3000));
		else if (pick < 8)
			clock_ns += (quiet_limit_ns > 32'd100000) ? {32'd0, $urandom} :
				{32'd0, $urandom_range(0, 3 * quiet_limit_ns + 10)};
		else
			clock_ns += 64'($urandom_range(0, 400));

		pick = $urandom_range(0, 19);
		if (pick == 0)
			sched = {$urandom, $urandom};
		else if (pick <= 3)
			sched = clock_ns + 64'($urandom_range(0, 200));
		else
			sched = clock_ns - 64'($urandom_range(0, 400));

		pick = $urandom_range(0, 9);
		diff = 0;
		if (pick <= 3)
			diff = int'(dom_thr_mv) + int'($urandom_range(0, 1500));
		else if (pick <= 6)
			diff = int'(rec_thr_mv) - int'($urandom_range(0, 1500));
		else if (pick == 7)
			diff = int'($urandom_range(rec_thr_mv, dom_thr_mv));
		else if (pick == 8)
			diff = $urandom_range(0, 1) ? int'(dom_thr_mv) : int'(rec_thr_mv);

		if (pick == 9) begin
			h = ctmr_pkg::MV_W'($urandom_range(0, 5000));
			l = ctmr_pkg::MV_W'($urandom_range(0, 5000));
		end else begin
			if (diff > 5000)
				diff = 5000;
			if (diff < -5000)
				diff = -5000;
			if (diff >= 0) begin
				lo = $urandom_range(0, 5000 - diff);
				h  = ctmr_pkg::MV_W'(lo + diff);
				l  = ctmr_pkg::MV_W'(lo);
			end else begin
				lo = $urandom_range(0, 5000 + diff);
				h  = ctmr_pkg::MV_W'(lo);
				l  = ctmr_pkg::MV_W'(lo - diff);
			end
		end
		queue_sample(cur_mode, 1'($urandom_range(0, 1)), h, l, clock_ns, sched);
	endtask

	// Sender: feed the queued samples, predicting each one as it transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				taken.mode  = op_mode;
				taken.txd   = txd_low;
				taken.canh  = canh_mv;
				taken.canl  = canl_mv;
				taken.now   = now_ns;
				taken.sched = sched_ns;
				bus_results_due.push_back(predict_transceiver_step(taken));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (samples_to_send.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!steady && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 7);
					in_valid <= 1'b0;
				end else begin
					next_sample = samples_to_send.pop_front();
					in_valid <= 1'b1;
					op_mode  <= next_sample.mode;
					txd_low  <= next_sample.txd;
					canh_mv  <= next_sample.canh;
					canl_mv  <= next_sample.canl;
					now_ns   <= next_sample.now;
					sched_ns <= next_sample.sched;
				end
			end
		end
	end

	// Receiver: check each result transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (bus_results_due.size() == 0) begin
					$error("result transfer with no sample outstanding");
					mismatch_count++;
				end else begin
					want = bus_results_due.pop_front();
					compare_field("fsm_state", 64'(want.st), 64'(fsm_state));
					compare_field("drv_en", 64'(want.drv), 64'(drv_en));
					compare_field("rcv_en", 64'(want.rcv), 64'(rcv_en));
					compare_field("canh_out_mv", 64'(want.canh), 64'(canh_out_mv));
					compare_field("canl_out_mv", 64'(want.canl), 64'(canl_out_mv));
					compare_field("rxd_level", 64'(want.rxd), 64'(rxd_level));
					compare_field("bus_class", 64'(want.cls), 64'(bus_class));
					results_matched++;
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 11) == 0) begin
				hold_off = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults straight out of reset
		queue_sample(ctmr_pkg::OPM_OFF, 1'b0, 13'd0, 13'd0, 64'd0, 64'd0);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b1, 13'd5000, 13'd0, 64'd0, 64'd0);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b1, 13'd1400, 13'd500, 64'd100, 64'd0);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b0, 13'd3000, 13'd2500, 64'd200, 64'd200);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b1, 13'd2200, 13'd1500, 64'd400, 64'd400);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b0, 13'd0, 13'd5000, 64'd600, 64'd600);
		queue_sample(ctmr_pkg::OPM_SILENT, 1'b1, 13'd3500, 13'd1500, 64'd700, 64'd0);
		queue_sample(OPM_LOW_POWER, 1'b1, 13'd3500, 13'd1500, 64'd800, 64'd800);
		queue_sample(OPM_LOW_POWER, 1'b0, 13'd2500, 13'd2500, 64'd1000000801,
			64'd1000000700);
		queue_sample(OPM_LOW_POWER, 1'b0, 13'd3500, 13'd1500, 64'd1000001000,
			64'd1000001000);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b1, 13'd2500, 13'd2500, 64'd1000001100,
			64'd1000001000);
		queue_sample(OPM_LOW_POWER, 1'b0, 13'd2500, 13'd2500, 64'd2000001101,
			64'd2000001101);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b0, 13'd3500, 13'd1500, 64'd2000001200,
			64'd2000001200);
		queue_sample(OPM_LOW_POWER, 1'b0, 13'd2500, 13'd2500, 64'd2000001300,
			64'd2000001300);
		// silence of exactly the timeout, then one more
		queue_sample(OPM_LOW_POWER, 1'b0, 13'd2500, 13'd2500, 64'd3000001200,
			64'd3000001200);
		queue_sample(OPM_LOW_POWER, 1'b0, 13'd2500, 13'd2500, 64'd3000001201,
			64'd3000001201);
		queue_sample(ctmr_pkg::OPM_OFF, 1'b1, 13'd3500, 13'd1500, 64'd3000001300,
			64'd3000001300);
		// delay sum and silence time wrapping past the top of the time range
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b1, 13'd3500, 13'd1500, TIME_MAX - 64'd15,
			TIME_MAX - 64'd15);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b1, 13'd5000, 13'd5000, TIME_MAX, TIME_MAX);
		queue_sample(OPM_LOW_POWER, 1'b0, 13'd2500, 13'd2500, 64'd50, 64'd0);
		queue_sample(ctmr_pkg::OPM_SILENT, 1'b0, 13'd0, 13'd0, 64'd60,
			64'hAAAA_AAAA_5555_5555);
		wait_bus_quiet();

		// Crossed thresholds, plus writes past the register list
		write_reg(ctmr_pkg::REG_DOM_THR, 32'd300);
		write_reg(ctmr_pkg::REG_REC_THR, 32'd800);
		write_reg(REG_PAST_END, $urandom);
		write_reg(REG_IDX_MAX, $urandom);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b1, 13'd3000, 13'd2500, 64'd100, 64'd0);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b0, 13'd2800, 13'd2500, 64'd200, 64'd200);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b1, 13'd2799, 13'd2500, 64'd400, 64'd400);
		queue_sample(ctmr_pkg::OPM_NORMAL, 1'b0, 13'd3301, 13'd2500, 64'd500, 64'd400);
		wait_bus_quiet();

		clock_ns = 64'd100;
		cur_mode = ctmr_pkg::OPM_NORMAL;
		for (int phase = 0; phase < 10; phase++) begin
			load_settings(phase);
			steady = (phase == 9) || ($urandom_range(0, 5) == 0);
			repeat (153) queue_random_sample();
			wait_bus_quiet();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && bus_results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
